>>> rtl/assert_macros.svh
// Assertion macros used by the top RTL file of the effective-address block.
// Define NO_ASSERTIONS to compile the design without its checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Implication checked at every rising edge outside reset.
`define MSEA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Condition that must never hold outside reset.
`define MSEA_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define MSEA_ASSERT(lbl, clk, rst_n, prop)
`define MSEA_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/msea_pkg.sv
// Types and encoding constants for the ModRM/SIB effective-address block.
// No dependencies; used by both modules.
package msea_pkg;

	localparam int unsigned RegIdxW = 4;
	localparam int unsigned RegW    = 64;

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_ADDR  = 1'b1;

	// ModRM mod field
	localparam logic [1:0] MOD_NODISP = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP32 = 2'd2;
	localparam logic [1:0] MOD_REG    = 2'd3;

	// ModRM rm field and SIB special encodings
	localparam logic [2:0] RM_SIB      = 3'd4;
	localparam logic [2:0] RM_DISP     = 3'd5;
	localparam logic [3:0] INDEX_NONE  = 4'd4;
	localparam logic [2:0] BASE_NONE   = 3'd5;

	// Address size codes
	localparam logic [1:0] ASZ_16 = 2'd0;
	localparam logic [1:0] ASZ_32 = 2'd1;
	localparam logic [1:0] ASZ_64 = 2'd2;

	localparam logic [3:0] REX_HIGH = 4'h4;

	typedef struct packed {
		logic       mem;
		logic       is_sib;
		logic       riprel;
		logic       no_base;
		logic       idx_none;
		logic [1:0] scale;
		logic [1:0] asz;
	} msea_ctrl_t;

endpackage

>>> rtl/msea_in_if.sv
// Input channel of the effective-address block: valid/ready plus one item.
// Depends on nothing but the field widths of the work item.
interface msea_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [3:0]  write_index;
	logic [63:0] write_value;
	logic [7:0]  modrm_byte;
	logic [7:0]  rex_byte;
	logic [39:0] following_bytes;
	logic [63:0] current_rip;
	logic [3:0]  instr_length;
	logic [1:0]  address_size;

	modport source (
		output valid, cmd, write_index, write_value, modrm_byte, rex_byte,
			following_bytes, current_rip, instr_length, address_size,
		input  ready
	);
	modport sink (
		input  valid, cmd, write_index, write_value, modrm_byte, rex_byte,
			following_bytes, current_rip, instr_length, address_size,
		output ready
	);
endinterface

>>> rtl/msea_out_if.sv
// Result channel of the effective-address block: valid/ready plus one result.
// Depends on nothing.
interface msea_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] effective_address;
	logic        memory_access;

	modport source (
		output valid, effective_address, memory_access,
		input  ready
	);
	modport sink (
		input  valid, effective_address, memory_access,
		output ready
	);
endinterface

>>> rtl/modrm_sib_effective_address_top.sv
// x86-64 ModRM/SIB effective-address generator with a 16-entry register file.
// Channel "in" carries work items: cmd 0 writes write_value into register
// write_index, cmd 1 computes the memory-operand address from modrm_byte,
// rex_byte, following_bytes, current_rip, instr_length and address_size.
// Channel "out" returns exactly one result per item, in order: the address
// and memory_access, both zero for writes and register operands (mod 3).
// Writes land in the register file at their transfer, so any later item
// sees them without delay.
// A result passes through the register-file read, the base/index add and
// the displacement add into the output register. Throughput: one item per
// cycle while the output holds no untaken result, set by the single write
// port and the two read ports of the register file.
// Reset empties the pipeline and makes every register read as zero until
// it is written. While the output holds an untaken result, the whole
// pipeline and in.ready stall; nothing is dropped.
module modrm_sib_effective_address_top
	import msea_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	msea_in_if.sink   in,
	msea_out_if.source out
);

`include "assert_macros.svh"

	logic en;
	logic accept;

	// decode of the incoming item
	logic [1:0]         mod;
	logic [2:0]         rm;
	logic               rex_ok;
	logic               rx;
	logic               rb;
	logic [7:0]         sib;
	logic [RegIdxW-1:0] idx;
	logic [RegIdxW-1:0] base_addr;
	logic [7:0]         d8;
	logic [31:0]        d32;
	logic [RegW-1:0]    d32_ext;
	logic [RegW-1:0]    disp;
	msea_ctrl_t         ctrl;

	// stage 1: register data returning from the file
	logic            valid_s1;
	msea_ctrl_t      ctrl_s1;
	logic [RegW-1:0] rip_s1;
	logic [RegW-1:0] disp_s1;
	logic [RegW-1:0] rd_a;
	logic [RegW-1:0] rd_b;
	logic [RegW-1:0] base_trunc;
	logic [RegW-1:0] term_a;
	logic [RegW-1:0] term_b;

	// stage 2: partial sum
	logic            valid_s2;
	logic            mem_s2;
	logic [RegW-1:0] sum_s2;
	logic [RegW-1:0] disp_s2;

	// output register
	logic            out_valid_q;
	logic [RegW-1:0] ea_q;
	logic            mem_q;

	assign en       = !out_valid_q || out.ready;
	assign in.ready = en;
	assign accept   = in.valid && en;

	always_comb begin
		mod       = in.modrm_byte[7:6];
		rm        = in.modrm_byte[2:0];
		rex_ok    = (in.rex_byte[7:4] == REX_HIGH);
		rx        = rex_ok && in.rex_byte[1];
		rb        = rex_ok && in.rex_byte[0];
		sib       = in.following_bytes[7:0];
		idx       = {rx, sib[5:3]};

		ctrl.mem      = (in.cmd == CMD_ADDR) && (mod != MOD_REG);
		ctrl.is_sib   = (rm == RM_SIB);
		ctrl.riprel   = (mod == MOD_NODISP) && (rm == RM_DISP);
		ctrl.no_base  = ctrl.is_sib && (mod == MOD_NODISP) && (sib[2:0] == BASE_NONE);
		ctrl.idx_none = (idx == INDEX_NONE);
		ctrl.scale    = sib[7:6];
		ctrl.asz      = in.address_size;

		base_addr = ctrl.is_sib ? {rb, sib[2:0]} : {rb, rm};

		// displacement starts after the SIB byte when there is one
		d8      = ctrl.is_sib ? in.following_bytes[15:8] : in.following_bytes[7:0];
		d32     = ctrl.is_sib ? in.following_bytes[39:8] : in.following_bytes[31:0];
		d32_ext = {{(RegW-32){d32[31]}}, d32};

		if (ctrl.riprel) begin
			disp = d32_ext + {{(RegW-4){1'b0}}, in.instr_length};
		end else if (ctrl.no_base) begin
			disp = d32_ext;
		end else begin
			case (mod)
				MOD_DISP8:  disp = {{(RegW-8){d8[7]}}, d8};
				MOD_DISP32: disp = d32_ext;
				default:    disp = '0;
			endcase
		end
	end

	msea_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (accept && (in.cmd == CMD_WRITE)),
		.waddr   (in.write_index),
		.wdata   (in.write_value),
		.re      (en),
		.raddr_a (idx),
		.raddr_b (base_addr),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= in.valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1 <= ctrl;
			rip_s1  <= in.current_rip;
			disp_s1 <= disp;
		end
	end

	always_comb begin
		unique case (ctrl_s1.asz)
			ASZ_16:  base_trunc = {{(RegW-16){1'b0}}, rd_b[15:0]};
			ASZ_32:  base_trunc = {{(RegW-32){1'b0}}, rd_b[31:0]};
			default: base_trunc = rd_b;
		endcase

		if (ctrl_s1.is_sib) begin
			term_a = ctrl_s1.idx_none ? '0 : (rd_a << ctrl_s1.scale);
			term_b = ctrl_s1.no_base ? '0 : rd_b;
		end else if (ctrl_s1.riprel) begin
			term_a = rip_s1;
			term_b = '0;
		end else begin
			term_a = base_trunc;
			term_b = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mem_s2  <= ctrl_s1.mem;
			sum_s2  <= term_a + term_b;
			disp_s2 <= disp_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mem_q <= mem_s2;
			ea_q  <= mem_s2 ? (sum_s2 + disp_s2) : '0;
		end
	end

	assign out.valid             = out_valid_q;
	assign out.effective_address = ea_q;
	assign out.memory_access     = mem_q;

	`MSEA_ASSERT(a_reg_operand_zero, clk, arst_n,
		(out.valid && !out.memory_access) |-> (out.effective_address == '0))
	`MSEA_ASSERT(a_write_no_access, clk, arst_n,
		(accept && (in.cmd == CMD_WRITE)) |=> (valid_s1 && !ctrl_s1.mem))
	`MSEA_ASSERT(a_stall_holds_pipe, clk, arst_n,
		!en |=> ($stable(valid_s1) && $stable(valid_s2) && $stable(sum_s2)))
	`MSEA_NEVER(a_sib_not_riprel, clk, arst_n,
		valid_s1 && ctrl_s1.is_sib && ctrl_s1.riprel)

endmodule

>>> rtl/msea_regfile.sv
// 16 x 64 general register file: one write port, two registered read ports.
// Per-entry valid bits make unwritten registers read as zero after reset.
module msea_regfile
	import msea_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               we,
	input  logic [RegIdxW-1:0] waddr,
	input  logic [RegW-1:0]    wdata,
	input  logic               re,
	input  logic [RegIdxW-1:0] raddr_a,
	input  logic [RegIdxW-1:0] raddr_b,
	output logic [RegW-1:0]    rdata_a,
	output logic [RegW-1:0]    rdata_b
);

	localparam int unsigned Depth = 2 ** RegIdxW;

	logic [RegW-1:0]  mem [Depth];
	logic [Depth-1:0] vld_q;
	logic [RegW-1:0]  rd_a_q;
	logic [RegW-1:0]  rd_b_q;
	logic             rd_a_vld_q;
	logic             rd_b_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_a_vld_q <= 1'b0;
			rd_b_vld_q <= 1'b0;
		end else if (re) begin
			rd_a_vld_q <= vld_q[raddr_a];
			rd_b_vld_q <= vld_q[raddr_b];
		end
	end

	assign rdata_a = rd_a_vld_q ? rd_a_q : '0;
	assign rdata_b = rd_b_vld_q ? rd_b_q : '0;

endmodule
